// File: src/pcdm_pkg.sv
// Shared widths, field offsets and codes for the PWM capture duty meter.
`default_nettype none

package pcdm_pkg;

   localparam int TIME_W     = 32;  // on / off time and overflow tally
   localparam int SPAN_W     = 17;  // timer_span register
   localparam int PERIOD_W   = 33;  // on + off without wrap
   localparam int DUTY_W     = 7;   // duty quotient, 0..100
   localparam int NUM_W      = TIME_W + DUTY_W;  // on_time * 100

   localparam logic [SPAN_W-1:0] SPAN_RESET = 17'h10000;

   // result tdata layout, lowest bit first
   localparam int ON_LSB      = 0;
   localparam int OFF_LSB     = ON_LSB + TIME_W;
   localparam int PERIOD_LSB  = OFF_LSB + TIME_W;
   localparam int DUTY_LSB    = PERIOD_LSB + PERIOD_W;
   localparam int RSP_TDATA_W = DUTY_LSB + DUTY_W;  // 104, whole bytes

   localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

   // req_tuser codes
   localparam logic OP_OVERFLOW = 1'b0;
   localparam logic OP_EDGE     = 1'b1;

endpackage

`default_nettype wire

// File: src/pcdm_mul.sv
// Bit-serial multiplier: low 32 bits of overflow tally times timer span.
`default_nettype none

module pcdm_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pcdm_pkg::TIME_W-1:0]   mcand,
   input  wire logic [pcdm_pkg::SPAN_W-1:0]   mplier,
   output logic                               done,
   output logic [pcdm_pkg::TIME_W-1:0]        product
);

   localparam int CNT_W = $clog2(pcdm_pkg::SPAN_W);

   logic [pcdm_pkg::TIME_W-1:0] acc_ff, acc_in;
   logic [pcdm_pkg::TIME_W-1:0] a_ff, a_in;
   logic [pcdm_pkg::SPAN_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   // multiplier bits enter MSB first; accumulator doubles each step
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = mcand;
         b_in    = mplier;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff << 1) + (b_ff[pcdm_pkg::SPAN_W-1] ? a_ff : '0);
         b_in   = b_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(pcdm_pkg::SPAN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// File: src/pcdm_div.sv
// Restoring divider, one quotient bit per cycle, for the duty percentage.
`default_nettype none

module pcdm_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pcdm_pkg::NUM_W-1:0]    num,   // on_time * 100
   input  wire logic [pcdm_pkg::PERIOD_W-1:0] den,   // period, num < 128 * den
   output logic                               done,
   output logic [pcdm_pkg::DUTY_W-1:0]        quot
);

   localparam int QW    = pcdm_pkg::DUTY_W;
   localparam int RW    = pcdm_pkg::PERIOD_W;
   localparam int CNT_W = $clog2(QW);

   logic [RW-1:0]    rem_ff, rem_in;
   logic [RW-1:0]    den_ff, den_in;
   logic [QW-1:0]    nlo_ff, nlo_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RW:0]      trial;
   logic [RW:0]      diff;
   logic             ge;

   assign trial = {rem_ff, nlo_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   // upper dividend bits start as the partial remainder: they are below den
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      nlo_in  = nlo_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = RW'(num[pcdm_pkg::NUM_W-1:QW]);
         den_in  = den;
         nlo_in  = num[QW-1:0];
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[RW-1:0] : trial[RW-1:0];
         q_in   = {q_ff[QW-2:0], ge};
         nlo_in = nlo_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      nlo_ff <= nlo_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// File: src/pwm_capture_duty_meter.sv
// Top level of the PWM capture duty meter: edge sequencer, state and result register.
// From req transfer to rsp_tvalid an edge passes through 17 multiplier steps, S_EDGE,
// S_DIVS, 7 divider steps and S_OUT; a timer overflow skips the multiplier.
// One item at a time: req_tready is low until the sequencer is back in idle; a
// stalled rsp register holds the sequencer in its output state until it drains.
// Reset (synchronous, active high) clears times, tally, stamps and span to 65536;
// the first edge after reset is taken as falling.
`default_nettype none

module pwm_capture_duty_meter #(
   parameter int COUNT_BITS = 16   // timer counter width, 8..32
) (
   input  wire logic clock,
   input  wire logic reset,

   // input items
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [((COUNT_BITS+7)/8)*8-1:0]     req_tdata,  // timer_count, zero pad
   input  wire logic                                req_tuser,  // operation

   // results
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // on_time[31:0], off_time[63:32], period_ticks[96:64], duty_percent[103:97]
   output logic [pcdm_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   output logic                                     rsp_tuser,  // duty_valid

   // timer_span register
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pcdm_pkg::SPAN_W-1:0]         csr_data
);

   localparam int TW = pcdm_pkg::TIME_W;
   localparam int PW = pcdm_pkg::PERIOD_W;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a req transfer
   localparam logic [2:0] S_MUL  = 3'd1;  // tally * span running
   localparam logic [2:0] S_EDGE = 3'd2;  // update on/off time and stamps
   localparam logic [2:0] S_DIVS = 3'd3;  // launch the duty divider
   localparam logic [2:0] S_DIVW = 3'd4;  // divider running
   localparam logic [2:0] S_OUT  = 3'd5;  // load the rsp register

   logic [2:0]                  state_ff, state_in;
   logic [pcdm_pkg::SPAN_W-1:0] span_ff, span_in;
   logic [TW-1:0]               on_ff, on_in;
   logic [TW-1:0]               off_ff, off_in;
   logic [TW-1:0]               tally_ff, tally_in;
   logic [COUNT_BITS-1:0]       rise_ff, rise_in;
   logic [COUNT_BITS-1:0]       fall_ff, fall_in;
   logic [COUNT_BITS-1:0]       count_ff, count_in;
   logic                        expect_rise_ff, expect_rise_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pcdm_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                        rsp_user_ff, rsp_user_in;

   logic                        req_xfer;
   logic                        mul_start, mul_done;
   logic [TW-1:0]               weight;
   logic                        div_start, div_done;
   logic [pcdm_pkg::DUTY_W-1:0] quot;
   logic [PW-1:0]               period;
   logic [pcdm_pkg::NUM_W-1:0]  on_wide, num;
   logic [TW-1:0]               other_stamp;
   logic [TW-1:0]               edge_ticks;
   logic                        period_nz;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;  // span must only be rewritten while idle; this block does not enforce it

   // period at full width; on * 100 as shifts, 39 bits
   assign period    = {1'b0, on_ff} + {1'b0, off_ff};
   assign period_nz = (period != '0);
   assign on_wide   = pcdm_pkg::NUM_W'(on_ff);
   assign num       = (on_wide << 6) + (on_wide << 5) + (on_wide << 2);

   // new time = count + tally * span - stamp of the opposite edge, mod 2^32
   assign other_stamp = expect_rise_ff ? TW'(fall_ff) : TW'(rise_ff);
   assign edge_ticks  = TW'(count_ff) + weight - other_stamp;

   // an edge starts the multiplier on the transfer itself
   assign mul_start = req_xfer && (req_tuser == pcdm_pkg::OP_EDGE);
   assign div_start = (state_ff == S_DIVS);

   pcdm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (tally_ff),
      .mplier  (span_ff),
      .done    (mul_done),
      .product (weight)
   );

   pcdm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (period),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      state_in       = state_ff;
      span_in        = span_ff;
      on_in          = on_ff;
      off_in         = off_ff;
      tally_in       = tally_ff;
      rise_in        = rise_ff;
      fall_in        = fall_ff;
      count_in       = count_ff;
      expect_rise_in = expect_rise_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;

      if (csr_valid && csr_ready) begin
         span_in = csr_data;
      end

      // rsp register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               count_in = req_tdata[COUNT_BITS-1:0];
               if (req_tuser == pcdm_pkg::OP_EDGE) begin
                  state_in = S_MUL;
               end else begin
                  tally_in = tally_ff + 1'b1;  // wraps mod 2^32
                  state_in = S_DIVS;
               end
            end
         end
         S_MUL: begin
            if (mul_done) begin
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            if (expect_rise_ff) begin
               rise_in = count_ff;
               off_in  = edge_ticks;
            end else begin
               fall_in = count_ff;
               on_in   = edge_ticks;
            end
            tally_in       = '0;
            expect_rise_in = !expect_rise_ff;
            state_in       = S_DIVS;
         end
         S_DIVS: begin
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in[pcdm_pkg::ON_LSB +: TW]     = on_ff;
               rsp_data_in[pcdm_pkg::OFF_LSB +: TW]    = off_ff;
               rsp_data_in[pcdm_pkg::PERIOD_LSB +: PW] = period;
               // zero period: divider output is meaningless, force duty to 0
               rsp_data_in[pcdm_pkg::DUTY_LSB +: pcdm_pkg::DUTY_W] =
                  period_nz ? quot : '0;
               rsp_user_in = period_nz;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         span_ff        <= pcdm_pkg::SPAN_RESET;
         on_ff          <= '0;
         off_ff         <= '0;
         tally_ff       <= '0;
         rise_ff        <= '0;
         fall_ff        <= '0;
         expect_rise_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         span_ff        <= span_in;
         on_ff          <= on_in;
         off_ff         <= off_in;
         tally_ff       <= tally_in;
         rise_ff        <= rise_in;
         fall_ff        <= fall_in;
         expect_rise_ff <= expect_rise_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// File: src/pcdm_chk.sv
// Port-level checker for the PWM capture duty meter, bound to the top level.
`default_nettype none

module pcdm_chk (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [pcdm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic                              rsp_tuser
);

   logic [pcdm_pkg::TIME_W-1:0]   on_t, off_t;
   logic [pcdm_pkg::PERIOD_W-1:0] period_t;
   logic [pcdm_pkg::DUTY_W-1:0]   duty_t;

   assign on_t     = rsp_tdata[pcdm_pkg::ON_LSB +: pcdm_pkg::TIME_W];
   assign off_t    = rsp_tdata[pcdm_pkg::OFF_LSB +: pcdm_pkg::TIME_W];
   assign period_t = rsp_tdata[pcdm_pkg::PERIOD_LSB +: pcdm_pkg::PERIOD_W];
   assign duty_t   = rsp_tdata[pcdm_pkg::DUTY_LSB +: pcdm_pkg::DUTY_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   a_period_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> period_t == ({1'b0, on_t} + {1'b0, off_t}))
      else $error("period is not on + off");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> duty_t <= pcdm_pkg::DUTY_MAX)
      else $error("duty above 100");

   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> period_t == '0 && duty_t == '0)
      else $error("invalid duty with nonzero period or duty");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind pwm_capture_duty_meter pcdm_chk u_pcdm_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
